[hdl/priority_pool_burst_scheduler_unit_assert.svh]
// Assertion macros for the priority pool burst scheduler.
`ifndef PRIORITY_POOL_BURST_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_POOL_BURST_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication under the block clock, disabled during reset.
`define PPBS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ppbs: same-cycle check failed");
// Next-cycle implication under the block clock, disabled during reset.
`define PPBS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ppbs: next-cycle check failed");
`else
`define PPBS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define PPBS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

[hdl/ppbs_pkg.sv]
// Shared types and constants of the priority pool burst scheduler.
package ppbs_pkg;

    localparam int unsigned CNT_W  = 48;
    localparam int unsigned RUN_W  = 16;
    localparam int unsigned WAIT_W = 32;
    localparam int unsigned PRIO_W = 8;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_PICK = 2'd1,
        CMD_POP  = 2'd2
    } ppbs_cmd_t;

    typedef enum logic {
        ALU_ADD,
        ALU_LE
    } ppbs_alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POP_RD,
        ST_POP_EV,
        ST_ARM_EV,
        ST_ARM_TK,
        ST_SCAN_EV,
        ST_SCAN_TK,
        ST_PICK_END,
        ST_DONE
    } ppbs_state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        pool_index;
        logic [7:0]        priority_req;
        logic [15:0]       burst_pops;
        logic [15:0]       success_limit;
        logic [31:0]       success_wait_events;
        logic [31:0]       fail_wait_events;
        logic [31:0]       success_wait_ticks;
        logic [31:0]       fail_wait_ticks;
        logic              thread_found;
        logic [47:0]       now_ticks;
    } ppbs_in_t;

    typedef struct packed {
        logic              pick_valid;
        logic [2:0]        picked_pool;
        logic              burst_open;
        logic [47:0]       event_total;
        logic              misuse;
    } ppbs_out_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [RUN_W-1:0]  min_s;
        logic [RUN_W-1:0]  max_s;
        logic [WAIT_W-1:0] succ_ev;
        logic [WAIT_W-1:0] fail_ev;
        logic [WAIT_W-1:0] succ_tk;
        logic [WAIT_W-1:0] fail_tk;
    } ppbs_policy_t;

    typedef struct packed {
        logic load;
        logic ev_we;
        logic tk_we;
    } ppbs_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ppbs_stat_t;

endpackage

[hdl/ppbs_alu.sv]
// Shared 48-bit saturating adder and less-or-equal comparator.
module ppbs_alu
(
    input  ppbs_pkg::ppbs_alu_op_t       op,
    input  logic [ppbs_pkg::CNT_W-1:0]   a,
    input  logic [ppbs_pkg::CNT_W-1:0]   b,
    output logic [ppbs_pkg::CNT_W-1:0]   sum,
    output logic                         le
);

    logic [ppbs_pkg::CNT_W-1:0] x;
    logic [ppbs_pkg::CNT_W-1:0] y;
    logic                       cin;
    logic [ppbs_pkg::CNT_W:0]   s;

    // For a compare the adder forms b - a; its carry out is set when a <= b.
    always_comb
    begin
        if (op == ppbs_pkg::ALU_LE)
        begin
            x   = b;
            y   = ~a;
            cin = 1'b1;
        end
        else
        begin
            x   = a;
            y   = b;
            cin = 1'b0;
        end
        s = {1'b0, x} + {1'b0, y} + {{ppbs_pkg::CNT_W{1'b0}}, cin};
    end

    assign sum = s[ppbs_pkg::CNT_W] ? '1 : s[ppbs_pkg::CNT_W-1:0];
    assign le  = s[ppbs_pkg::CNT_W];

endmodule

[hdl/ppbs_store.sv]
// Per-pool policy and ready-time memories with valid bits for the ready times.
module ppbs_store
#(
    parameter int POOL_COUNT = 8,
    parameter int PW         = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [PW-1:0]                 rd_addr,
    input  logic [PW-1:0]                 wr_addr,
    input  ppbs_pkg::ppbs_wr_t            wr,
    input  ppbs_pkg::ppbs_policy_t        pol_wdata,
    input  logic [ppbs_pkg::CNT_W-1:0]    cnt_wdata,
    output ppbs_pkg::ppbs_policy_t        pol_rd,
    output logic [ppbs_pkg::CNT_W-1:0]    ev_rd,
    output logic [ppbs_pkg::CNT_W-1:0]    tk_rd
);

    ppbs_pkg::ppbs_policy_t     pol_mem [POOL_COUNT];
    logic [ppbs_pkg::CNT_W-1:0] ev_mem  [POOL_COUNT];
    logic [ppbs_pkg::CNT_W-1:0] tk_mem  [POOL_COUNT];

    logic [POOL_COUNT-1:0]      ev_vld_reg;
    logic [POOL_COUNT-1:0]      tk_vld_reg;
    logic                       ev_v_reg;
    logic                       tk_v_reg;
    ppbs_pkg::ppbs_policy_t     pol_rd_reg;
    logic [ppbs_pkg::CNT_W-1:0] ev_rd_reg;
    logic [ppbs_pkg::CNT_W-1:0] tk_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            pol_mem[wr_addr] <= pol_wdata;
        end
        if (wr.ev_we)
        begin
            ev_mem[wr_addr] <= cnt_wdata;
        end
        if (wr.tk_we)
        begin
            tk_mem[wr_addr] <= cnt_wdata;
        end
        pol_rd_reg <= pol_mem[rd_addr];
        ev_rd_reg  <= ev_mem[rd_addr];
        tk_rd_reg  <= tk_mem[rd_addr];
    end

    // A ready time that was never armed since reset or the last load reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg <= '0;
            tk_vld_reg <= '0;
            ev_v_reg   <= 1'b0;
            tk_v_reg   <= 1'b0;
        end
        else
        begin
            if (wr.load)
            begin
                ev_vld_reg[wr_addr] <= 1'b0;
                tk_vld_reg[wr_addr] <= 1'b0;
            end
            if (wr.ev_we)
            begin
                ev_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr.tk_we)
            begin
                tk_vld_reg[wr_addr] <= 1'b1;
            end
            ev_v_reg <= ev_vld_reg[rd_addr];
            tk_v_reg <= tk_vld_reg[rd_addr];
        end
    end

    assign pol_rd = pol_rd_reg;
    assign ev_rd  = ev_v_reg ? ev_rd_reg : '0;
    assign tk_rd  = tk_v_reg ? tk_rd_reg : '0;

endmodule

[hdl/ppbs_ctrl.sv]
// Sequencer that runs load, pick scan and pop outcome steps over the shared ALU.
module ppbs_ctrl
#(
    parameter int POOL_COUNT = 8,
    parameter int PW         = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  ppbs_pkg::ppbs_in_t            req_item,
    input  logic                          slot_free,
    output ppbs_pkg::ppbs_stat_t          stat,
    output ppbs_pkg::ppbs_out_t           result,
    output logic [PW-1:0]                 rd_addr,
    output logic [PW-1:0]                 wr_addr,
    output ppbs_pkg::ppbs_wr_t            wr,
    output ppbs_pkg::ppbs_policy_t        pol_wdata,
    output logic [ppbs_pkg::CNT_W-1:0]    cnt_wdata,
    input  ppbs_pkg::ppbs_policy_t        pol_rd,
    input  logic [ppbs_pkg::CNT_W-1:0]    ev_rd,
    input  logic [ppbs_pkg::CNT_W-1:0]    tk_rd,
    output ppbs_pkg::ppbs_alu_op_t        alu_op,
    output logic [ppbs_pkg::CNT_W-1:0]    alu_a,
    output logic [ppbs_pkg::CNT_W-1:0]    alu_b,
    input  logic [ppbs_pkg::CNT_W-1:0]    alu_sum,
    input  logic                          alu_le
);

    localparam logic [PW-1:0] LAST_POOL = PW'(POOL_COUNT - 1);

    ppbs_pkg::ppbs_state_t          state_reg, state_next;
    ppbs_pkg::ppbs_in_t             item_reg, item_next;
    logic [ppbs_pkg::CNT_W-1:0]     ev_cnt_reg, ev_cnt_next;
    logic                           last_valid_reg, last_valid_next;
    logic [PW-1:0]                  last_pool_reg, last_pool_next;
    logic [ppbs_pkg::RUN_W-1:0]     run_reg, run_next;
    logic [ppbs_pkg::RUN_W-1:0]     pops_reg, pops_next;
    logic                           burst_reg, burst_next;
    logic                           misuse_reg, misuse_next;
    logic [PW-1:0]                  scan_reg, scan_next;
    logic                           ok_ev_reg, ok_ev_next;
    logic                           found_reg, found_next;
    logic [PW-1:0]                  best_reg, best_next;
    logic [ppbs_pkg::PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [ppbs_pkg::RUN_W-1:0]     best_min_reg, best_min_next;
    logic                           arm_succ_reg, arm_succ_next;

    logic                           accept;
    logic                           load_ok;
    logic                           pop_ok;
    logic [ppbs_pkg::RUN_W-1:0]     run_inc;

    assign accept  = req_valid && (state_reg == ppbs_pkg::ST_IDLE);
    assign load_ok = {4'd0, item_reg.pool_index} < 7'(POOL_COUNT);
    assign pop_ok  = burst_reg && last_valid_reg;
    assign run_inc = (run_reg == '1) ? run_reg : run_reg + 16'd1;

    assign pol_wdata.prio    = item_reg.priority_req;
    assign pol_wdata.min_s   = item_reg.burst_pops;
    assign pol_wdata.max_s   = item_reg.success_limit;
    assign pol_wdata.succ_ev = item_reg.success_wait_events;
    assign pol_wdata.fail_ev = item_reg.fail_wait_events;
    assign pol_wdata.succ_tk = item_reg.success_wait_ticks;
    assign pol_wdata.fail_tk = item_reg.fail_wait_ticks;
    assign cnt_wdata         = alu_sum;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppbs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_item.cmd)
                        ppbs_pkg::CMD_LOAD: state_next = ppbs_pkg::ST_LOAD;
                        ppbs_pkg::CMD_PICK: state_next = ppbs_pkg::ST_SCAN_EV;
                        ppbs_pkg::CMD_POP:
                        begin
                            state_next = pop_ok ? ppbs_pkg::ST_POP_RD : ppbs_pkg::ST_DONE;
                        end
                        default:            state_next = ppbs_pkg::ST_DONE;
                    endcase
                end
            end
            ppbs_pkg::ST_LOAD:     state_next = ppbs_pkg::ST_DONE;
            ppbs_pkg::ST_POP_RD:   state_next = ppbs_pkg::ST_POP_EV;
            ppbs_pkg::ST_POP_EV:
            begin
                if (!item_reg.thread_found || (run_inc >= pol_rd.max_s))
                begin
                    state_next = ppbs_pkg::ST_ARM_EV;
                end
                else
                begin
                    state_next = ppbs_pkg::ST_DONE;
                end
            end
            ppbs_pkg::ST_ARM_EV:   state_next = ppbs_pkg::ST_ARM_TK;
            ppbs_pkg::ST_ARM_TK:   state_next = ppbs_pkg::ST_DONE;
            ppbs_pkg::ST_SCAN_EV:  state_next = ppbs_pkg::ST_SCAN_TK;
            ppbs_pkg::ST_SCAN_TK:
            begin
                state_next = (scan_reg == LAST_POOL) ? ppbs_pkg::ST_PICK_END
                                                     : ppbs_pkg::ST_SCAN_EV;
            end
            ppbs_pkg::ST_PICK_END: state_next = ppbs_pkg::ST_DONE;
            ppbs_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ppbs_pkg::ST_IDLE;
                end
            end
            default:               state_next = ppbs_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and register updates per state.
    always_comb
    begin
        item_next       = item_reg;
        ev_cnt_next     = ev_cnt_reg;
        last_valid_next = last_valid_reg;
        last_pool_next  = last_pool_reg;
        run_next        = run_reg;
        pops_next       = pops_reg;
        burst_next      = burst_reg;
        misuse_next     = misuse_reg;
        scan_next       = scan_reg;
        ok_ev_next      = ok_ev_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_prio_next  = best_prio_reg;
        best_min_next   = best_min_reg;
        arm_succ_next   = arm_succ_reg;
        rd_addr         = last_pool_reg;
        wr_addr         = last_pool_reg;
        wr              = '0;
        alu_op          = ppbs_pkg::ALU_ADD;
        alu_a           = ev_cnt_reg;
        alu_b           = '0;

        case (state_reg)
            ppbs_pkg::ST_IDLE:
            begin
                // Pool zero is read ahead so a pick scan can start right away.
                rd_addr = '0;
                if (accept)
                begin
                    item_next   = req_item;
                    misuse_next = (req_item.cmd == ppbs_pkg::CMD_POP) && !pop_ok;
                    scan_next   = '0;
                    found_next  = 1'b0;
                end
            end
            ppbs_pkg::ST_LOAD:
            begin
                if (load_ok)
                begin
                    wr.load = 1'b1;
                    wr_addr = PW'(item_reg.pool_index);
                end
            end
            ppbs_pkg::ST_POP_RD:
            begin
                rd_addr = last_pool_reg;
            end
            ppbs_pkg::ST_POP_EV:
            begin
                rd_addr = last_pool_reg;
                if (item_reg.thread_found)
                begin
                    alu_b         = 48'd1;
                    ev_cnt_next   = alu_sum;
                    run_next      = run_inc;
                    arm_succ_next = 1'b1;
                    if (run_inc < pol_rd.max_s)
                    begin
                        pops_next  = pops_reg - 16'd1;
                        burst_next = (pops_reg != 16'd1);
                    end
                end
                else
                begin
                    arm_succ_next = 1'b0;
                end
            end
            ppbs_pkg::ST_ARM_EV:
            begin
                rd_addr  = last_pool_reg;
                alu_a    = ev_cnt_reg;
                alu_b    = {16'd0, arm_succ_reg ? pol_rd.succ_ev : pol_rd.fail_ev};
                wr.ev_we = 1'b1;
            end
            ppbs_pkg::ST_ARM_TK:
            begin
                rd_addr    = last_pool_reg;
                alu_a      = item_reg.now_ticks;
                alu_b      = {16'd0, arm_succ_reg ? pol_rd.succ_tk : pol_rd.fail_tk};
                wr.tk_we   = 1'b1;
                run_next   = '0;
                burst_next = 1'b0;
                pops_next  = '0;
            end
            ppbs_pkg::ST_SCAN_EV:
            begin
                rd_addr    = scan_reg;
                alu_op     = ppbs_pkg::ALU_LE;
                alu_a      = ev_rd;
                alu_b      = ev_cnt_reg;
                ok_ev_next = alu_le;
            end
            ppbs_pkg::ST_SCAN_TK:
            begin
                rd_addr = (scan_reg == LAST_POOL) ? '0 : scan_reg + PW'(1);
                alu_op  = ppbs_pkg::ALU_LE;
                alu_a   = tk_rd;
                alu_b   = item_reg.now_ticks;
                if (ok_ev_reg && alu_le && (!found_reg || (pol_rd.prio < best_prio_reg)))
                begin
                    found_next     = 1'b1;
                    best_next      = scan_reg;
                    best_prio_next = pol_rd.prio;
                    best_min_next  = pol_rd.min_s;
                end
                if (scan_reg != LAST_POOL)
                begin
                    scan_next = scan_reg + PW'(1);
                end
            end
            ppbs_pkg::ST_PICK_END:
            begin
                burst_next = found_reg && (best_min_reg != '0);
                pops_next  = found_reg ? best_min_reg : '0;
                if ((found_reg != last_valid_reg) || (found_reg && (best_reg != last_pool_reg)))
                begin
                    last_valid_next = found_reg;
                    last_pool_next  = found_reg ? best_reg : '0;
                    run_next        = '0;
                end
                if (!found_reg)
                begin
                    alu_b       = 48'd1;
                    ev_cnt_next = alu_sum;
                end
            end
            ppbs_pkg::ST_DONE:
            begin
                rd_addr = last_pool_reg;
            end
            default:
            begin
                rd_addr = last_pool_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppbs_pkg::ST_IDLE;
            ev_cnt_reg     <= '0;
            last_valid_reg <= 1'b0;
            last_pool_reg  <= '0;
            run_reg        <= '0;
            pops_reg       <= '0;
            burst_reg      <= 1'b0;
            misuse_reg     <= 1'b0;
            scan_reg       <= '0;
            ok_ev_reg      <= 1'b0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ev_cnt_reg     <= ev_cnt_next;
            last_valid_reg <= last_valid_next;
            last_pool_reg  <= last_pool_next;
            run_reg        <= run_next;
            pops_reg       <= pops_next;
            burst_reg      <= burst_next;
            misuse_reg     <= misuse_next;
            scan_reg       <= scan_next;
            ok_ev_reg      <= ok_ev_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        best_prio_reg <= best_prio_next;
        best_min_reg  <= best_min_next;
        arm_succ_reg  <= arm_succ_next;
    end

    assign stat.busy = (state_reg != ppbs_pkg::ST_IDLE);
    assign stat.done = (state_reg == ppbs_pkg::ST_DONE) && slot_free;

    assign result.pick_valid  = last_valid_reg;
    assign result.picked_pool = 3'(last_pool_reg);
    assign result.burst_open  = burst_reg;
    assign result.event_total = ev_cnt_reg;
    assign result.misuse      = misuse_reg;

endmodule

[hdl/priority_pool_burst_scheduler_unit.sv]
// Top level of the priority pool burst scheduler: sequencer, shared ALU, stores, result register.
//
// One request channel (req_valid, req_stall, req_item) and one response channel
// (rsp_valid, rsp_stall, rsp_item); an item moves when valid is high and stall low.
// Every request item yields exactly one response item carrying the scheduler state.
// Items are handled one at a time; req_stall is high from acceptance until the
// sequencer has placed the result in the response register.
// Steps after acceptance: load ST_LOAD; pick ST_SCAN_EV and ST_SCAN_TK per pool, then
// ST_PICK_END; pop outcome ST_POP_RD, ST_POP_EV, then ST_ARM_EV, ST_ARM_TK when the pool's
// waits are armed; an ignored pop or unknown command goes straight to ST_DONE.
// The next item can be accepted once rsp_valid rises. A pick scans pools one at a time: the
// single 48-bit adder compares the event ready time in ST_SCAN_EV and the tick one in ST_SCAN_TK.
// The response register frees the sequencer, so a new item can be accepted while
// the previous result still waits; a stalled receiver holds the block in its
// final step once a second result is ready.
// Reset clears the counters, the burst, the chosen pool and all ready times;
// a pool's policy must be loaded before any pick.
`include "priority_pool_burst_scheduler_unit_assert.svh"

module priority_pool_burst_scheduler_unit
#(
    parameter int POOL_COUNT = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  ppbs_pkg::ppbs_in_t     req_item,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output ppbs_pkg::ppbs_out_t    rsp_item
);

    localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

    ppbs_pkg::ppbs_stat_t        stat;
    ppbs_pkg::ppbs_out_t         result;
    logic [PW-1:0]               rd_addr;
    logic [PW-1:0]               wr_addr;
    ppbs_pkg::ppbs_wr_t          wr;
    ppbs_pkg::ppbs_policy_t      pol_wdata;
    logic [ppbs_pkg::CNT_W-1:0]  cnt_wdata;
    ppbs_pkg::ppbs_policy_t      pol_rd;
    logic [ppbs_pkg::CNT_W-1:0]  ev_rd;
    logic [ppbs_pkg::CNT_W-1:0]  tk_rd;
    ppbs_pkg::ppbs_alu_op_t      alu_op;
    logic [ppbs_pkg::CNT_W-1:0]  alu_a;
    logic [ppbs_pkg::CNT_W-1:0]  alu_b;
    logic [ppbs_pkg::CNT_W-1:0]  alu_sum;
    logic                        alu_le;
    logic                        slot_free;
    logic                        rsp_valid_reg;
    ppbs_pkg::ppbs_out_t         rsp_item_reg;

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    ppbs_ctrl
    #(
        .POOL_COUNT (POOL_COUNT),
        .PW         (PW)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_item  (req_item),
        .slot_free (slot_free),
        .stat      (stat),
        .result    (result),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .pol_wdata (pol_wdata),
        .cnt_wdata (cnt_wdata),
        .pol_rd    (pol_rd),
        .ev_rd     (ev_rd),
        .tk_rd     (tk_rd),
        .alu_op    (alu_op),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_sum   (alu_sum),
        .alu_le    (alu_le)
    );

    ppbs_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .le  (alu_le)
    );

    ppbs_store
    #(
        .POOL_COUNT (POOL_COUNT),
        .PW         (PW)
    )
    u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .pol_wdata (pol_wdata),
        .cnt_wdata (cnt_wdata),
        .pol_rd    (pol_rd),
        .ev_rd     (ev_rd),
        .tk_rd     (tk_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            rsp_item_reg <= result;
        end
    end

    assign req_stall = stat.busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    `PPBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    `PPBS_ASSERT_IMPL(a_done_while_busy, clk, rst_n, stat.done, req_stall)
    `PPBS_ASSERT_IMPL(a_burst_has_pool, clk, rst_n, rsp_valid && rsp_item.burst_open, rsp_item.pick_valid)
    `PPBS_ASSERT_IMPL(a_misuse_no_burst, clk, rst_n, rsp_valid && rsp_item.misuse, !rsp_item.burst_open)

endmodule
